/* rtl/idea_pkg.sv */
// Shared types, constants and the modulo 65537 multiply for the IDEA cipher core.
// No dependencies; every other file in rtl/ imports this package.
`default_nettype none

package idea_pkg;

    localparam int WORD_W          = 16;
    localparam int BLOCK_W         = 64;
    localparam int KEY_W           = 128;
    localparam int LANES           = 6;
    localparam int ROUND_COUNT_DEF = 8;
    localparam int APB_DATA_W      = 64;
    localparam int APB_ADDR_W      = 5;
    localparam int INV_STEPS       = 16;
    localparam int KEY_ROT         = 25;

    // Register indexes, taken from paddr[4:3].
    localparam logic [1:0] REG_KEY_HIGH = 2'd0;
    localparam logic [1:0] REG_KEY_LOW  = 2'd1;
    localparam logic [1:0] REG_MODE     = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_KLOAD,
        ST_KGEN,
        ST_TRD,
        ST_TWR,
        ST_TINV,
        ST_TIWR,
        ST_RND_A,
        ST_RND_B,
        ST_RND_C,
        ST_OUT
    } idea_state_t;

    typedef enum logic [1:0] {
        OP_COPY,
        OP_NEG,
        OP_INV
    } tbl_op_t;

    typedef struct packed {
        logic    kload;
        logic    ek_we;
        logic    krot;
        logic    inv_load;
        logic    inv_step;
        tbl_op_t op;
    } ks_cmd_t;

    typedef struct packed {
        logic load;
        logic do_a;
        logic do_b;
        logic do_c;
        logic do_out;
    } rnd_cmd_t;

    // Multiply modulo 65537 where the word 0 stands for 65536.
    function automatic logic [WORD_W-1:0] idea_mul(input logic [WORD_W-1:0] a,
                                                   input logic [WORD_W-1:0] b);
        logic [2*WORD_W-1:0] p;
        logic [WORD_W-1:0]   lo;
        logic [WORD_W-1:0]   hi;
        logic [WORD_W-1:0]   r;
        p  = {{WORD_W{1'b0}}, a} * {{WORD_W{1'b0}}, b};
        lo = p[WORD_W-1:0];
        hi = p[2*WORD_W-1:WORD_W];
        if (a == '0) begin
            r = WORD_W'(1) - b;
        end else if (b == '0) begin
            r = WORD_W'(1) - a;
        end else begin
            r = lo - hi + {{(WORD_W-1){1'b0}}, (lo < hi)};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* rtl/idea_ctrl.sv */
// Sequencer for the IDEA core: key expansion, subkey table build and the rounds.
// Depends on idea_pkg; drives idea_ksdp and idea_rnddp through command structs.
`default_nettype none

module idea_ctrl
    import idea_pkg::*;
#(
    parameter int ROUND_COUNT = ROUND_COUNT_DEF,
    parameter int EK_N        = 6 * ROUND_COUNT + 4,
    parameter int SRC_W       = $clog2(EK_N),
    parameter int ROW_W       = $clog2(ROUND_COUNT + 1)
)(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic             cfg_wr,
    input  wire logic             decrypt,
    output logic                  busy,
    output ks_cmd_t               ks_cmd,
    output rnd_cmd_t              rnd_cmd,
    output logic [SRC_W-1:0]      ek_addr,
    output logic                  sk_we,
    output logic [ROW_W-1:0]      sk_row,
    output logic [2:0]            sk_lane,
    output logic [ROW_W-1:0]      rd_row
);

    localparam logic [SRC_W-1:0] LAST_IDX  = SRC_W'(EK_N - 1);
    localparam logic [SRC_W-1:0] BASE_TOP  = SRC_W'(6 * ROUND_COUNT);
    localparam logic [ROW_W-1:0] LAST_ROW  = ROW_W'(ROUND_COUNT);
    localparam logic [ROW_W-1:0] LAST_RND  = ROW_W'(ROUND_COUNT - 1);

    idea_state_t      state_reg, state_next;
    logic [SRC_W-1:0] idx_reg, idx_next;
    logic [SRC_W-1:0] base_reg, base_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [2:0]       lane_reg, lane_next;
    logic [3:0]       inv_cnt_reg, inv_cnt_next;

    logic             edge_row;
    tbl_op_t          op;
    logic [SRC_W-1:0] src;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg   <= ST_KLOAD;
            idx_reg     <= '0;
            base_reg    <= '0;
            row_reg     <= '0;
            lane_reg    <= '0;
            inv_cnt_reg <= '0;
        end else begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            base_reg    <= base_next;
            row_reg     <= row_next;
            lane_reg    <= lane_next;
            inv_cnt_reg <= inv_cnt_next;
        end
    end

    // Where each decryption subkey comes from in the expanded key.
    always_comb begin
        edge_row = (row_reg == '0) || (row_reg == LAST_ROW);
        op       = OP_COPY;
        src      = idx_reg;
        if (decrypt) begin
            unique case (lane_reg)
                3'd0: begin
                    op  = OP_INV;
                    src = base_reg;
                end
                3'd1: begin
                    op  = OP_NEG;
                    src = base_reg + (edge_row ? SRC_W'(1) : SRC_W'(2));
                end
                3'd2: begin
                    op  = OP_NEG;
                    src = base_reg + (edge_row ? SRC_W'(2) : SRC_W'(1));
                end
                3'd3: begin
                    op  = OP_INV;
                    src = base_reg + SRC_W'(3);
                end
                3'd4: src = base_reg - SRC_W'(2);
                3'd5: src = base_reg - SRC_W'(1);
                default: src = base_reg;
            endcase
        end
    end

    always_comb begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        base_next    = base_reg;
        row_next     = row_reg;
        lane_next    = lane_reg;
        inv_cnt_next = inv_cnt_reg;
        ks_cmd       = '0;
        ks_cmd.op    = op;
        rnd_cmd      = '0;
        sk_we        = 1'b0;
        ek_addr      = src;
        busy         = 1'b1;

        unique case (state_reg)
            ST_IDLE: begin
                busy     = cfg_wr;
                row_next = '0;
                if (cfg_wr) begin
                    state_next = ST_KLOAD;
                end else if (start) begin
                    rnd_cmd.load = 1'b1;
                    state_next   = ST_RND_A;
                end
            end
            ST_KLOAD: begin
                ks_cmd.kload = 1'b1;
                idx_next     = '0;
                state_next   = ST_KGEN;
            end
            ST_KGEN: begin
                ek_addr      = idx_reg;
                ks_cmd.ek_we = 1'b1;
                ks_cmd.krot  = (idx_reg[2:0] == 3'd7);
                idx_next     = idx_reg + SRC_W'(1);
                if (idx_reg == LAST_IDX) begin
                    idx_next   = '0;
                    base_next  = BASE_TOP;
                    row_next   = '0;
                    lane_next  = '0;
                    state_next = ST_TRD;
                end
            end
            ST_TRD: begin
                state_next = ST_TWR;
            end
            ST_TWR: begin
                if (op == OP_INV) begin
                    ks_cmd.inv_load = 1'b1;
                    inv_cnt_next    = '0;
                    state_next      = ST_TINV;
                end else begin
                    sk_we = 1'b1;
                end
            end
            ST_TINV: begin
                ks_cmd.inv_step = 1'b1;
                inv_cnt_next    = inv_cnt_reg + 4'd1;
                if (inv_cnt_reg == 4'(INV_STEPS - 1)) begin
                    state_next = ST_TIWR;
                end
            end
            ST_TIWR: begin
                sk_we = 1'b1;
            end
            ST_RND_A: begin
                rnd_cmd.do_a = 1'b1;
                state_next   = ST_RND_B;
            end
            ST_RND_B: begin
                rnd_cmd.do_b = 1'b1;
                state_next   = ST_RND_C;
            end
            ST_RND_C: begin
                rnd_cmd.do_c = 1'b1;
                row_next     = row_reg + ROW_W'(1);
                state_next   = (row_reg == LAST_RND) ? ST_OUT : ST_RND_A;
            end
            ST_OUT: begin
                rnd_cmd.do_out = 1'b1;
                state_next     = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase

        // One table entry written: step to the next lane and row.
        if (sk_we) begin
            idx_next   = idx_reg + SRC_W'(1);
            state_next = ST_TRD;
            if (lane_reg == 3'(LANES - 1)) begin
                lane_next = '0;
                row_next  = row_reg + ROW_W'(1);
                base_next = base_reg - SRC_W'(6);
            end else begin
                lane_next = lane_reg + 3'd1;
            end
            if (idx_reg == LAST_IDX) begin
                state_next = ST_IDLE;
            end
        end

        // A new key or mode during the rebuild starts it over.
        if (cfg_wr && state_reg != ST_IDLE && state_reg != ST_RND_A &&
            state_reg != ST_RND_B && state_reg != ST_RND_C && state_reg != ST_OUT) begin
            state_next = ST_KLOAD;
        end
    end

    assign sk_row  = row_reg;
    assign sk_lane = lane_reg;
    assign rd_row  = row_next;

endmodule

`default_nettype wire

/* rtl/idea_ksdp.sv */
// Key schedule datapath: configuration registers, expanded key memory and the
// modular inverse unit. Depends on idea_pkg; commanded by idea_ctrl.
`default_nettype none

module idea_ksdp
    import idea_pkg::*;
#(
    parameter int ROUND_COUNT = ROUND_COUNT_DEF,
    parameter int EK_N        = 6 * ROUND_COUNT + 4,
    parameter int SRC_W       = $clog2(EK_N)
)(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_wr,
    input  wire logic [1:0]            cfg_idx,
    input  wire logic [APB_DATA_W-1:0] cfg_wdata,
    input  wire logic [1:0]            rd_idx,
    output logic [APB_DATA_W-1:0]      rd_data,
    output logic                       decrypt,
    input  wire ks_cmd_t               ks_cmd,
    input  wire logic [SRC_W-1:0]      ek_addr,
    output logic [WORD_W-1:0]          tbl_data
);

    logic [BLOCK_W-1:0] key_high_reg;
    logic [BLOCK_W-1:0] key_low_reg;
    logic               mode_reg;
    logic [KEY_W-1:0]   krot_reg;
    logic [WORD_W-1:0]  ek_mem [EK_N];
    logic [WORD_W-1:0]  ek_rd_reg;
    logic [WORD_W-1:0]  inv_res_reg;
    logic [WORD_W-1:0]  inv_base_reg;
    logic [WORD_W-1:0]  ek_word;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            key_high_reg <= '0;
            key_low_reg  <= '0;
            mode_reg     <= 1'b0;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_KEY_HIGH: key_high_reg <= cfg_wdata;
                REG_KEY_LOW:  key_low_reg  <= cfg_wdata;
                REG_MODE:     mode_reg     <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (rd_idx)
            REG_KEY_HIGH: rd_data = key_high_reg;
            REG_KEY_LOW:  rd_data = key_low_reg;
            REG_MODE:     rd_data = {{(APB_DATA_W-1){1'b0}}, mode_reg};
            default:      rd_data = '0;
        endcase
    end

    assign decrypt = mode_reg;

    // Each group of eight subkeys is the key rotated left by 25 more bits.
    always_ff @(posedge clk) begin
        if (ks_cmd.kload) begin
            krot_reg <= {key_high_reg, key_low_reg};
        end else if (ks_cmd.krot) begin
            krot_reg <= {krot_reg[KEY_W-KEY_ROT-1:0], krot_reg[KEY_W-1:KEY_W-KEY_ROT]};
        end
    end

    assign ek_word = krot_reg[KEY_W-1-WORD_W*ek_addr[2:0] -: WORD_W];

    always_ff @(posedge clk) begin
        if (ks_cmd.ek_we) begin
            ek_mem[ek_addr] <= ek_word;
        end
        ek_rd_reg <= ek_mem[ek_addr];
    end

    // Inverse as x^65535 by square and multiply, one exponent bit per cycle.
    always_ff @(posedge clk) begin
        if (ks_cmd.inv_load) begin
            inv_res_reg  <= WORD_W'(1);
            inv_base_reg <= ek_rd_reg;
        end else if (ks_cmd.inv_step) begin
            inv_res_reg  <= idea_mul(inv_res_reg, inv_base_reg);
            inv_base_reg <= idea_mul(inv_base_reg, inv_base_reg);
        end
    end

    always_comb begin
        case (ks_cmd.op)
            OP_NEG:  tbl_data = WORD_W'(0) - ek_rd_reg;
            OP_INV:  tbl_data = inv_res_reg;
            default: tbl_data = ek_rd_reg;
        endcase
    end

endmodule

`default_nettype wire

/* rtl/idea_rnddp.sv */
// Round datapath: subkey table memory, block word registers and the result register.
// Depends on idea_pkg; commanded by idea_ctrl, table written from idea_ksdp.
`default_nettype none

module idea_rnddp
    import idea_pkg::*;
#(
    parameter int ROUND_COUNT = ROUND_COUNT_DEF,
    parameter int ROW_N       = ROUND_COUNT + 1,
    parameter int ROW_W       = $clog2(ROUND_COUNT + 1)
)(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire rnd_cmd_t           rnd_cmd,
    input  wire logic               sk_we,
    input  wire logic [ROW_W-1:0]   sk_row,
    input  wire logic [2:0]         sk_lane,
    input  wire logic [WORD_W-1:0]  sk_data,
    input  wire logic [ROW_W-1:0]   rd_row,
    input  wire logic [BLOCK_W-1:0] data_block,
    output logic [BLOCK_W-1:0]      result_block,
    output logic                    done
);

    logic [LANES*WORD_W-1:0] sk_mem [ROW_N];
    logic [LANES*WORD_W-1:0] krow_reg;
    logic [WORD_W-1:0]       x1_reg, x2_reg, x3_reg, x4_reg, a_reg;
    logic [BLOCK_W-1:0]      result_reg;
    logic                    done_reg;
    logic [WORD_W-1:0]       z0, z1, z2, z3, z4, z5;
    logic [WORD_W-1:0]       b, ab;

    always_ff @(posedge clk) begin
        if (sk_we) begin
            sk_mem[sk_row][WORD_W*sk_lane +: WORD_W] <= sk_data;
        end
        krow_reg <= sk_mem[rd_row];
    end

    assign z0 = krow_reg[0*WORD_W +: WORD_W];
    assign z1 = krow_reg[1*WORD_W +: WORD_W];
    assign z2 = krow_reg[2*WORD_W +: WORD_W];
    assign z3 = krow_reg[3*WORD_W +: WORD_W];
    assign z4 = krow_reg[4*WORD_W +: WORD_W];
    assign z5 = krow_reg[5*WORD_W +: WORD_W];

    assign b  = idea_mul(((x2_reg ^ x4_reg) + a_reg), z5);
    assign ab = a_reg + b;

    // A round runs as key mixing, then the first MA multiply, then the second MA multiply.
    always_ff @(posedge clk) begin
        if (rnd_cmd.load) begin
            x1_reg <= data_block[63:48];
            x2_reg <= data_block[47:32];
            x3_reg <= data_block[31:16];
            x4_reg <= data_block[15:0];
        end else if (rnd_cmd.do_a) begin
            x1_reg <= idea_mul(x1_reg, z0);
            x2_reg <= x2_reg + z1;
            x3_reg <= x3_reg + z2;
            x4_reg <= idea_mul(x4_reg, z3);
        end else if (rnd_cmd.do_b) begin
            a_reg <= idea_mul(x1_reg ^ x3_reg, z4);
        end else if (rnd_cmd.do_c) begin
            x1_reg <= x1_reg ^ b;
            x2_reg <= x3_reg ^ b;
            x3_reg <= x2_reg ^ ab;
            x4_reg <= x4_reg ^ ab;
        end
        if (rnd_cmd.do_out) begin
            result_reg <= {idea_mul(x1_reg, z0), x3_reg + z1, x2_reg + z2,
                           idea_mul(x4_reg, z3)};
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            done_reg <= 1'b0;
        end else begin
            done_reg <= rnd_cmd.do_out;
        end
    end

    assign result_block = result_reg;
    assign done         = done_reg;

endmodule

`default_nettype wire

/* rtl/idea_block_cipher.sv */
// Top level of the IDEA block cipher core: APB register port, sequencer and datapaths.
// Depends on idea_pkg, idea_ctrl, idea_ksdp and idea_rnddp.
//
//   Channel   Signals                               Transaction
//   config    psel penable pwrite paddr pwdata      write at access phase, pready tied high
//             prdata pready
//   input     start busy data_block                 start high while busy low
//   result    done result_block                     done high for one cycle
//
// A new item is accepted only in idle, once the previous one is through:
// each round runs on one shared round datapath, then the output transform.
// The result is registered from the last step; it cannot be stalled.
// After reset and after every register write outside a running block the subkey table
// is rebuilt while busy is high: key expansion, then each table entry read and written,
// with one of the 2*ROUND_COUNT+2 inverses computed for some entries in decrypt mode.
`default_nettype none

module idea_block_cipher
    import idea_pkg::*;
#(
    parameter int ROUND_COUNT = ROUND_COUNT_DEF
)(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0]      prdata,
    output logic                       pready,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic [BLOCK_W-1:0]    data_block,
    output logic                       done,
    output logic [BLOCK_W-1:0]         result_block
);

    localparam int EK_N  = 6 * ROUND_COUNT + 4;
    localparam int SRC_W = $clog2(EK_N);
    localparam int ROW_W = $clog2(ROUND_COUNT + 1);

    logic              cfg_wr;
    logic              decrypt;
    ks_cmd_t           ks_cmd;
    rnd_cmd_t          rnd_cmd;
    logic [SRC_W-1:0]  ek_addr;
    logic              sk_we;
    logic [ROW_W-1:0]  sk_row;
    logic [2:0]        sk_lane;
    logic [ROW_W-1:0]  rd_row;
    logic [WORD_W-1:0] tbl_data;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    idea_ctrl #(
        .ROUND_COUNT (ROUND_COUNT)
    ) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .cfg_wr  (cfg_wr),
        .decrypt (decrypt),
        .busy    (busy),
        .ks_cmd  (ks_cmd),
        .rnd_cmd (rnd_cmd),
        .ek_addr (ek_addr),
        .sk_we   (sk_we),
        .sk_row  (sk_row),
        .sk_lane (sk_lane),
        .rd_row  (rd_row)
    );

    idea_ksdp #(
        .ROUND_COUNT (ROUND_COUNT)
    ) u_ksdp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr    (cfg_wr),
        .cfg_idx   (paddr[4:3]),
        .cfg_wdata (pwdata),
        .rd_idx    (paddr[4:3]),
        .rd_data   (prdata),
        .decrypt   (decrypt),
        .ks_cmd    (ks_cmd),
        .ek_addr   (ek_addr),
        .tbl_data  (tbl_data)
    );

    idea_rnddp #(
        .ROUND_COUNT (ROUND_COUNT)
    ) u_rnddp (
        .clk          (clk),
        .rst_n        (rst_n),
        .rnd_cmd      (rnd_cmd),
        .sk_we        (sk_we),
        .sk_row       (sk_row),
        .sk_lane      (sk_lane),
        .sk_data      (tbl_data),
        .rd_row       (rd_row),
        .data_block   (data_block),
        .result_block (result_block),
        .done         (done)
    );

endmodule

`default_nettype wire
